>>> hw/rtl/sha256_byte_stream_hasher_assert.svh
// Assertion macros for the byte-stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// check that a condition implies a consequence on the same edge
`define SHA_ASSERT_IMP(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// check that a condition implies a consequence on the next edge
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/sha_pkg.sv
package sha_pkg;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_ABSORB  = 2'd1,
		OP_FINISH  = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	localparam int unsigned WORDS = 8;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS = 64;

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		begin
			case (i)
				3'd0: r = 32'h6a09e667;
				3'd1: r = 32'hbb67ae85;
				3'd2: r = 32'h3c6ef372;
				3'd3: r = 32'ha54ff53a;
				3'd4: r = 32'h510e527f;
				3'd5: r = 32'h9b05688c;
				3'd6: r = 32'h1f83d9ab;
				default: r = 32'h5be0cd19;
			endcase
			return r;
		end
	endfunction

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// message schedule step
	function automatic logic [31:0] sched_next(input logic [31:0] w16, input logic [31:0] w15,
			input logic [31:0] w7, input logic [31:0] w2);
		logic [31:0] s0;
		logic [31:0] s1;
		begin
			s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
			s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
			return w16 + s0 + w7 + s1;
		end
	endfunction

	// control from sequencer to round unit
	typedef struct packed {
		logic load;
		logic round;
		logic [5:0] idx;
	} rnd_ctl_t;

endpackage

>>> hw/rtl/sha_if.sv
interface sha_in_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [7:0] message_byte;
	modport source(output valid, output operation, output message_byte, input ready);
	modport sink(input valid, input operation, input message_byte, output ready);
endinterface

interface sha_out_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;
	modport source(output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink(input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

>>> hw/rtl/sha256_byte_stream_hasher.sv
// Byte-stream SHA-256 hasher.
// Input channel in_ch carries operation and message_byte; it is ready only
// while the sequencer is idle, so one item is handled at a time. Restart loads
// the standard initial hash and clears length and fill in its accept cycle.
// Absorb steps through accept, read of the block word and merged write back.
// The byte that fills a block adds one compression: load, then for rounds
// 0..15 a read of the block word and the round, for rounds 16..63 four
// single-port reads of the rolling schedule and then the round, and the
// chain add; that byte holds the input until the chain add is done.
// Finish pads byte by byte up to byte 55, writes the length words in WRB and
// SCH and compresses; from fill 56 up it pads to 63, compresses, pads a
// second block from 0 and compresses again. The first word is valid the
// cycle after the last compression ends. Read emits right after its accept.
// Output channel out_ch gives digest_word, word_index and last_word, most
// significant word first, one word per cycle while out_ch.ready is high; a
// stall holds the word in place and no item is accepted until all eight go.
// The block memory is written in full by absorb and padding before any
// compression reads it, so no clearing pass is needed; arst_n resets chain
// values, length, fill and the sequencer.
module sha256_byte_stream_hasher (
	input  logic clk,
	input  logic arst_n,
	sha_in_if.sink in_ch,
	sha_out_if.source out_ch
);
	`include "sha256_byte_stream_hasher_assert.svh"

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_WRB   = 10'b0000000010,
		ST_PAD   = 10'b0000000100,
		ST_LOAD  = 10'b0000001000,
		ST_RD    = 10'b0000010000,
		ST_RND   = 10'b0000100000,
		ST_ADD   = 10'b0001000000,
		ST_EMIT  = 10'b0010000000,
		ST_RMW   = 10'b0100000000,
		ST_SCH   = 10'b1000000000
	} state_t;

	state_t st_q;
	logic [31:0] chain_q [8];
	logic [63:0] len_q;
	logic [5:0] fill_q;
	logic [5:0] pad_q;
	logic fin_q;
	logic two_q;
	logic [5:0] rnd_q;
	logic [1:0] sch_q;
	logic [3:0] sidx_q;
	logic [31:0] tap_q [3];
	logic [7:0] byte_q;
	logic [2:0] oidx_q;
	logic ovalid_q;

	// block memory: 16 words, reused as rolling schedule
	logic [31:0] mem [16];
	logic [31:0] rdata_q;
	logic [3:0] raddr;
	logic rd_en;
	logic [3:0] waddr;
	logic [31:0] wdata;
	logic we;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	sha_pkg::rnd_ctl_t ctl;
	logic [31:0] vars [8];
	logic [31:0] wnew;

	sha_round u_round (
		.clk(clk),
		.ctl(ctl),
		.init_vars(chain_q),
		.w(wnew),
		.vars(vars)
	);

	// sequencing: rounds 0..15 take block word directly; later rounds need
	// four reads (w-16, w-15, w-7, w-2) and write the new word back in place
	logic [3:0] r4;
	assign r4 = rnd_q[3:0];

	always_comb begin
		raddr = 4'd0;
		case (sch_q)
			2'd0: raddr = r4;
			2'd1: raddr = r4 + 4'd1;
			2'd2: raddr = r4 + 4'd9;
			default: raddr = r4 + 4'd14;
		endcase
		if (st_q == ST_RMW) begin
			raddr = fill_q[5:2];
		end
		if (st_q == ST_PAD) begin
			raddr = pad_q[5:2];
		end
	end

	assign wnew = (rnd_q < 6'd16) ? rdata_q
		: sha_pkg::sched_next(tap_q[0], tap_q[1], tap_q[2], rdata_q);

	// byte merge for absorb and padding
	logic [5:0] bpos;
	logic [7:0] bval;
	logic [31:0] merged;
	always_comb begin
		bpos = fin_q ? pad_q : fill_q;
		bval = fin_q ? ((pad_q == fill_q) ? 8'h80 : 8'h00) : byte_q;
		merged = rdata_q;
		case (bpos[1:0])
			2'd0: merged[31:24] = bval;
			2'd1: merged[23:16] = bval;
			2'd2: merged[15:8] = bval;
			default: merged[7:0] = bval;
		endcase
	end

	logic pad_len;
	assign pad_len = fin_q && (pad_q == 6'd56) && !two_q;

	always_comb begin
		we = 1'b0;
		waddr = bpos[5:2];
		wdata = merged;
		if (st_q == ST_WRB) begin
			we = 1'b1;
			if (pad_len) begin
				waddr = 4'd14;
				wdata = len_q[63:32];
			end
		end
		if (st_q == ST_SCH && pad_len) begin
			we = 1'b1;
			waddr = 4'd15;
			wdata = len_q[31:0];
		end
		if (st_q == ST_RND && rnd_q >= 6'd16) begin
			we = 1'b1;
			waddr = r4;
			wdata = wnew;
		end
	end

	always_comb begin
		rd_en = (st_q == ST_RMW) || (st_q == ST_PAD) || (st_q == ST_RD)
			|| (st_q == ST_LOAD);
		ctl.load = (st_q == ST_LOAD);
		ctl.round = (st_q == ST_RND);
		ctl.idx = rnd_q;
	end

	assign in_ch.ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha_pkg::init_hash(3'(i));
			end
			len_q <= '0;
			fill_q <= '0;
			pad_q <= '0;
			fin_q <= 1'b0;
			two_q <= 1'b0;
			rnd_q <= '0;
			sch_q <= '0;
			sidx_q <= '0;
			oidx_q <= '0;
			ovalid_q <= 1'b0;
			byte_q <= '0;
			for (int i = 0; i < 3; i++) begin
				tap_q[i] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						byte_q <= in_ch.message_byte;
						case (sha_pkg::op_t'(in_ch.operation))
							sha_pkg::OP_RESTART: begin
								for (int i = 0; i < 8; i++) begin
									chain_q[i] <= sha_pkg::init_hash(3'(i));
								end
								len_q <= '0;
								fill_q <= '0;
							end
							sha_pkg::OP_ABSORB: begin
								len_q <= len_q + 64'd8;
								fin_q <= 1'b0;
								st_q <= ST_RMW;
							end
							sha_pkg::OP_FINISH: begin
								fin_q <= 1'b1;
								pad_q <= fill_q;
								two_q <= (fill_q >= 6'd56);
								st_q <= ST_PAD;
							end
							default: begin
								oidx_q <= '0;
								ovalid_q <= 1'b1;
								st_q <= ST_EMIT;
							end
						endcase
					end
				end
				// read word holding the byte, then merge it
				ST_RMW: begin
					st_q <= ST_WRB;
				end
				ST_PAD: begin
					st_q <= ST_WRB;
				end
				ST_WRB: begin
					if (!fin_q) begin
						fill_q <= fill_q + 6'd1;
						st_q <= (fill_q == 6'd63) ? ST_LOAD : ST_IDLE;
					end else if (pad_len) begin
						st_q <= ST_SCH;
					end else begin
						pad_q <= pad_q + 6'd1;
						st_q <= (pad_q == 6'd63) ? ST_LOAD : ST_PAD;
					end
					rnd_q <= '0;
					sch_q <= '0;
				end
				// second length word written here
				ST_SCH: begin
					st_q <= ST_LOAD;
				end
				ST_LOAD: begin
					st_q <= ST_RD;
				end
				// gather schedule taps, one memory read per cycle
				ST_RD: begin
					if (rnd_q < 6'd16 || sch_q == 2'd3) begin
						st_q <= ST_RND;
					end else begin
						sch_q <= sch_q + 2'd1;
					end
					if (rnd_q >= 6'd16 && sch_q != 2'd0) begin
						tap_q[sch_q - 2'd1] <= rdata_q;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					sch_q <= 2'd0;
					if (rnd_q == 6'd63) begin
						st_q <= ST_ADD;
					end else begin
						st_q <= ST_RD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + vars[i];
					end
					if (!fin_q) begin
						fill_q <= '0;
						st_q <= ST_IDLE;
					end else if (two_q) begin
						two_q <= 1'b0;
						pad_q <= '0;
						st_q <= ST_PAD;
					end else begin
						fill_q <= '0;
						oidx_q <= '0;
						ovalid_q <= 1'b1;
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							ovalid_q <= 1'b0;
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			sidx_q <= raddr;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.digest_word = chain_q[oidx_q];
	assign out_ch.word_index = oidx_q;
	assign out_ch.last_word = (oidx_q == 3'd7);

	`SHA_ASSERT_IMP(a_valid_emit, clk, arst_n, out_ch.valid, st_q == ST_EMIT)
	`SHA_ASSERT_IMP(a_busy, clk, arst_n, in_ch.ready, !out_ch.valid)
	`SHA_ASSERT_NEXT(a_last, clk, arst_n, out_ch.valid && out_ch.ready && out_ch.last_word,
		!out_ch.valid)
	`SHA_ASSERT_IMP(a_sidx, clk, arst_n, st_q == ST_RND && rnd_q < 6'd16, sidx_q == rnd_q[3:0])
endmodule

>>> hw/rtl/sha_round.sv
// Round datapath: working variables a..h and one round per cycle while ctl.round is high.
module sha_round (
	input  logic clk,
	input  sha_pkg::rnd_ctl_t ctl,
	input  logic [31:0] init_vars [8],
	input  logic [31:0] w,
	output logic [31:0] vars [8]
);
	logic [31:0] v_q [8];
	logic [31:0] t1;
	logic [31:0] t2;

	// compress one round
	always_comb begin
		t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
			^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::ROUND_K[ctl.idx] + w;
		t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= init_vars;
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign vars = v_q;
endmodule

>>> dv/sha256_byte_stream_hasher_checker.sv
module sha256_byte_stream_hasher_checker (
	input  logic clk,
	input  logic arst_n,
	sha_in_if    in_ch,
	sha_out_if   out_ch,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} hash_word_t;

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	hash_word_t  expected_words [$];
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [63:0] msg_bits;
	int unsigned fill;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	// place one byte big-endian into the block
	function automatic void place_byte(input int unsigned pos, input logic [7:0] b);
		blk[pos / 4][8 * (3 - pos % 4) +: 8] = b;
	endfunction

	// run the 64-round compression on the current block
	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = blk[t];
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + w[r];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	// append 0x80, zero fill and the length; spill into a second block when needed
	function automatic void pad_message();
		int unsigned p;
		p = fill;
		place_byte(p, 8'h80);
		p++;
		if (p > 56) begin
			for (; p < 64; p++)
				place_byte(p, 8'h00);
			compress_block();
			p = 0;
		end
		for (; p < 56; p++)
			place_byte(p, 8'h00);
		blk[14] = msg_bits[63:32];
		blk[15] = msg_bits[31:0];
		compress_block();
		fill = 0;
	endfunction

	function automatic void queue_chain();
		hash_word_t hw;
		for (int i = 0; i < 8; i++) begin
			hw.word = chain[i];
			hw.idx  = i[2:0];
			hw.last = (i == 7);
			expected_words.push_back(hw);
		end
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hash_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				chain[i] = START_HASH[i];
			for (int i = 0; i < 16; i++)
				blk[i] = '0;
			msg_bits = '0;
			fill = 0;
			expected_words.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// compare each accepted word with the oldest expectation
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", out_ch.digest_word, '0);
				end else begin
					want = expected_words.pop_front();
					if (out_ch.digest_word !== want.word)
						report("digest_word", out_ch.digest_word, want.word);
					if (out_ch.word_index !== want.idx)
						report("word_index", 32'(out_ch.word_index), 32'(want.idx));
					if (out_ch.last_word !== want.last)
						report("last_word", 32'(out_ch.last_word), 32'(want.last));
				end
			end
			// advance the predicted state on each accepted item
			if (in_ch.valid && in_ch.ready) begin
				case (sha_pkg::op_t'(in_ch.operation))
					sha_pkg::OP_RESTART: begin
						for (int i = 0; i < 8; i++)
							chain[i] = START_HASH[i];
						msg_bits = '0;
						fill = 0;
					end
					sha_pkg::OP_ABSORB: begin
						place_byte(fill, in_ch.message_byte);
						msg_bits = msg_bits + 64'd8;
						fill++;
						if (fill == 64) begin
							compress_block();
							fill = 0;
						end
					end
					sha_pkg::OP_FINISH: begin
						pad_message();
						queue_chain();
					end
					default: queue_chain();
				endcase
			end
			pending = expected_words.size();
		end
	end
endmodule

>>> dv/sha256_byte_stream_hasher_tb.sv
module sha256_byte_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   items_sent = 0;
	int   burst_left = 0;
	bit   hold_req = 1'b0;

	sha_in_if  in_ch ();
	sha_out_if out_ch ();

	sha256_byte_stream_hasher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sha256_byte_stream_hasher_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stall pattern chosen from three modes, long hold-off on request
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (cycles % 64 == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// offer one item, idling between bursts
	task automatic send(input sha_pkg::op_t op, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.message_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// hold the input idle until every expected word has arrived
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_message(input int nbytes);
		send(sha_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 60) == 0)
				send(sha_pkg::OP_READ, 8'($urandom_range(0, 255)));
			send(sha_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
		end
		send(sha_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int len;
		in_ch.valid = 1'b0;
		in_ch.operation = sha_pkg::OP_RESTART;
		in_ch.message_byte = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: read of initial hash, empty message, byte extremes, double finish
		send(sha_pkg::OP_READ, 8'hff);
		send(sha_pkg::OP_FINISH, 8'h00);
		send(sha_pkg::OP_RESTART, 8'hff);
		send(sha_pkg::OP_ABSORB, 8'h00);
		send(sha_pkg::OP_ABSORB, 8'hff);
		send(sha_pkg::OP_ABSORB, 8'ha5);
		send(sha_pkg::OP_ABSORB, 8'h5a);
		send(sha_pkg::OP_FINISH, 8'hff);
		send(sha_pkg::OP_FINISH, 8'h00);
		send(sha_pkg::OP_ABSORB, 8'h80);
		send(sha_pkg::OP_ABSORB, 8'h7f);
		send(sha_pkg::OP_READ, 8'h00);
		send(sha_pkg::OP_FINISH, 8'h55);
		send(sha_pkg::OP_RESTART, 8'h00);
		send(sha_pkg::OP_READ, 8'haa);

		// pause until everything has come back
		drain();

		// receiver holds off while reads keep coming, so the block stalls its input
		hold_req = 1'b1;
		repeat (4) send(sha_pkg::OP_READ, 8'($urandom_range(0, 255)));

		// random messages, lengths weighted around the padding boundaries
		while (items_sent < 350) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(55, 57);
				1: len = $urandom_range(63, 65);
				2: len = $urandom_range(110, 130);
				3: len = 119 + $urandom_range(0, 1);
				default: len = $urandom_range(0, 50);
			endcase
			send_message(len);
			// noise: continue past the digest or throw in stray items
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 6))
					send(sha_pkg::op_t'(2'($urandom_range(0, 3))),
						8'($urandom_range(0, 255)));
				send(sha_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
